[hw/rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int TCW_COLUMNS = 80;
    localparam int TCW_ROWS    = 25;

    localparam int TCW_CHAR_WIDTH   = 8;
    localparam int TCW_INDEX_WIDTH  = 11;
    localparam int TCW_COLOR_WIDTH  = 4;
    localparam int TCW_CELL_WIDTH   = 16;
    localparam int TCW_ROW_WIDTH    = 5;
    localparam int TCW_COLUMN_WIDTH = 7;

    localparam int TCW_S_TDATA_WIDTH = 24;
    localparam int TCW_M_TDATA_WIDTH = 32;
    localparam int TCW_CFG_IDX_WIDTH = 2;

    localparam logic [TCW_CHAR_WIDTH-1:0] NEWLINE_CODE = 8'd10;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [TCW_CFG_IDX_WIDTH-1:0] REG_TEXT_COLOR       = 2'd0;
    localparam logic [TCW_CFG_IDX_WIDTH-1:0] REG_BACKGROUND_COLOR = 2'd1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SCROLL,
        ST_SCROLL_END
    } tcw_state_t;

    typedef struct packed {
        logic [TCW_ROW_WIDTH-1:0]    cursor_row;
        logic [TCW_COLUMN_WIDTH-1:0] cursor_column;
        logic                        scrolled;
        logic                        read_hit;
    } tcw_pend_t;

    typedef struct packed {
        logic [TCW_CELL_WIDTH-1:0]   read_data;
        logic                        scrolled;
        logic [TCW_COLUMN_WIDTH-1:0] cursor_column;
        logic [TCW_ROW_WIDTH-1:0]    cursor_row;
    } tcw_result_t;

endpackage

`default_nettype wire

[hw/rtl/text_console_writer.sv]
// Results: a request's result is registered in the pending stage, then in the output stage.
// Throughput: one request per cycle while not clearing or scrolling and while results are taken.
// A put or newline that scrolls holds off requests while the copy runs one cell per cycle
// through the memory, moving every row below the top one row up.
// Reset: synchronous, active low; cursor and colors go to zero, then a clearing
// pass zeroes every screen cell before requests are taken.
// ----------------------------------------------------------------------------
// text_console_writer
// Text console top level: stream ports, color registers and engine.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
    parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // requests
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // char_code [7:0], cell_index [18:8]
    input  wire logic [tcw_pkg::TCW_S_TDATA_WIDTH-1:0] s_axis_tdata,
    // opcode [0]
    input  wire logic [0:0]                            s_axis_tuser,
    // results
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // cursor_row [4:0], cursor_column [11:5], scrolled [12], read_data [28:13]
    output logic      [tcw_pkg::TCW_M_TDATA_WIDTH-1:0] m_axis_tdata,
    // color registers
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tcw_pkg::TCW_CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [tcw_pkg::TCW_COLOR_WIDTH-1:0]   cfg_data
);
    import tcw_pkg::*;

    logic [TCW_COLOR_WIDTH-1:0] text_color_reg, text_color_next;
    logic [TCW_COLOR_WIDTH-1:0] background_color_reg, background_color_next;
    tcw_result_t                result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg       <= '0;
            background_color_reg <= '0;
        end else begin
            text_color_reg       <= text_color_next;
            background_color_reg <= background_color_next;
        end
    end

    always_comb begin
        text_color_next       = text_color_reg;
        background_color_next = background_color_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TEXT_COLOR:       text_color_next       = cfg_data;
                REG_BACKGROUND_COLOR: background_color_next = cfg_data;
                default: ;
            endcase
        end
    end

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .opcode           (s_axis_tuser[0]),
        .char_code        (s_axis_tdata[7:0]),
        .cell_index       (s_axis_tdata[18:8]),
        .text_color       (text_color_reg),
        .background_color (background_color_reg),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_result       (result)
    );

    assign m_axis_tdata = {3'b000, result.read_data, result.scrolled,
                           result.cursor_column, result.cursor_row};

endmodule

`default_nettype wire

[hw/rtl/tcw_screen_ram.sv]
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic                               aclk,
    input  wire logic                               we,
    input  wire logic [AW-1:0]                      waddr,
    input  wire logic [tcw_pkg::TCW_CELL_WIDTH-1:0] wdata,
    input  wire logic                               re,
    input  wire logic [AW-1:0]                      raddr,
    output logic      [tcw_pkg::TCW_CELL_WIDTH-1:0] rdata
);
    import tcw_pkg::*;

    logic [TCW_CELL_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tcw_engine.sv]
// ----------------------------------------------------------------------------
// tcw_engine
// Cursor, clearing pass, scroll copy sequencer and result pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_engine #(
    parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
    parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                opcode,
    input  wire logic [tcw_pkg::TCW_CHAR_WIDTH-1:0]  char_code,
    input  wire logic [tcw_pkg::TCW_INDEX_WIDTH-1:0] cell_index,
    input  wire logic [tcw_pkg::TCW_COLOR_WIDTH-1:0] text_color,
    input  wire logic [tcw_pkg::TCW_COLOR_WIDTH-1:0] background_color,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output tcw_pkg::tcw_result_t                     out_result
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int CMPW  = ((AW > TCW_INDEX_WIDTH) ? AW : TCW_INDEX_WIDTH) + 1;

    localparam logic [AW-1:0]   LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0]   ROW_STEP    = AW'(COLUMNS);
    localparam logic [AW-1:0]   SCROLL_BASE = AW'((ROWS - 2) * COLUMNS);
    localparam logic [RW-1:0]   SCROLL_ROW  = RW'(ROWS - 2);
    localparam logic [CW-1:0]   X_LAST      = CW'(COLUMNS - 1);
    localparam logic [CMPW-1:0] CELLS_CMP   = CMPW'(CELLS);

    tcw_state_t state_reg, state_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [CW-1:0] cur_x_reg, cur_x_next;
    logic [RW-1:0] cur_y_reg, cur_y_next;
    logic [AW-1:0] cur_pos_reg, cur_pos_next;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic          copy_wr_valid_reg, copy_wr_valid_next;
    logic [AW-1:0] copy_wr_addr_reg, copy_wr_addr_next;
    logic          pend_valid_reg, pend_valid_next;
    tcw_pend_t     pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    tcw_result_t   out_reg, out_next;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [TCW_CELL_WIDTH-1:0] mem_wdata;
    logic                      mem_re;
    logic [AW-1:0]             mem_raddr;
    logic [TCW_CELL_WIDTH-1:0] mem_rdata;

    logic pend_adv;
    logic accept;
    logic wrap;
    logic read_in_range;

    assign pend_adv      = !out_valid_reg || out_ready;
    assign accept        = in_valid && in_ready;
    assign read_in_range = CMPW'(cell_index) < CELLS_CMP;
    assign out_valid     = out_valid_reg;
    assign out_result    = out_reg;

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            sweep_reg         <= '0;
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
            cur_pos_reg       <= '0;
            row_base_reg      <= '0;
            copy_wr_valid_reg <= 1'b0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg         <= state_next;
            sweep_reg         <= sweep_next;
            cur_x_reg         <= cur_x_next;
            cur_y_reg         <= cur_y_next;
            cur_pos_reg       <= cur_pos_next;
            row_base_reg      <= row_base_next;
            copy_wr_valid_reg <= copy_wr_valid_next;
            pend_valid_reg    <= pend_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        copy_wr_addr_reg <= copy_wr_addr_next;
        pend_reg         <= pend_next;
        out_reg          <= out_next;
    end

    always_comb begin
        state_next         = state_reg;
        sweep_next         = sweep_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        cur_pos_next       = cur_pos_reg;
        row_base_next      = row_base_reg;
        copy_wr_valid_next = copy_wr_valid_reg;
        copy_wr_addr_next  = copy_wr_addr_reg;
        pend_next          = pend_reg;
        in_ready           = 1'b0;
        wrap               = 1'b0;
        mem_we             = 1'b0;
        mem_waddr          = cur_pos_reg;
        mem_wdata          = {background_color, text_color, char_code};
        mem_re             = 1'b0;
        mem_raddr          = sweep_reg;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = '0;
                if (sweep_reg == LAST_CELL) begin
                    sweep_next = '0;
                    state_next = ST_RUN;
                end else begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            ST_RUN: begin
                in_ready = !pend_valid_reg || pend_adv;
                if (accept) begin
                    pend_next.cursor_row    = TCW_ROW_WIDTH'(cur_y_reg);
                    pend_next.cursor_column = TCW_COLUMN_WIDTH'(cur_x_reg);
                    pend_next.scrolled      = 1'b0;
                    pend_next.read_hit      = 1'b0;
                    if (opcode == OP_READ) begin
                        mem_re             = 1'b1;
                        mem_raddr          = AW'(cell_index);
                        pend_next.read_hit = read_in_range;
                    end else begin
                        if (char_code == NEWLINE_CODE) begin
                            wrap = 1'b1;
                        end else begin
                            mem_we = 1'b1;
                            wrap   = (cur_x_reg == X_LAST);
                        end
                        if (wrap) begin
                            cur_x_next = '0;
                            if (cur_y_reg == SCROLL_ROW) begin
                                // cursor stays on the row before last
                                row_base_next      = SCROLL_BASE;
                                cur_pos_next       = SCROLL_BASE;
                                sweep_next         = ROW_STEP;
                                copy_wr_valid_next = 1'b0;
                                state_next         = ST_SCROLL;
                                pend_next.scrolled = 1'b1;
                            end else begin
                                cur_y_next    = cur_y_reg + RW'(1);
                                row_base_next = row_base_reg + ROW_STEP;
                                cur_pos_next  = row_base_reg + ROW_STEP;
                            end
                        end else begin
                            cur_x_next   = cur_x_reg + CW'(1);
                            cur_pos_next = cur_pos_reg + AW'(1);
                        end
                        pend_next.cursor_row    = TCW_ROW_WIDTH'(cur_y_next);
                        pend_next.cursor_column = TCW_COLUMN_WIDTH'(cur_x_next);
                    end
                end
            end
            ST_SCROLL: begin
                // read a cell of the next row; the registered read data is written one row up
                mem_re             = 1'b1;
                mem_raddr          = sweep_reg;
                mem_we             = copy_wr_valid_reg;
                mem_waddr          = copy_wr_addr_reg;
                mem_wdata          = mem_rdata;
                copy_wr_valid_next = 1'b1;
                copy_wr_addr_next  = sweep_reg - ROW_STEP;
                if (sweep_reg == LAST_CELL) begin
                    state_next = ST_SCROLL_END;
                end else begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            ST_SCROLL_END: begin
                mem_we             = copy_wr_valid_reg;
                mem_waddr          = copy_wr_addr_reg;
                mem_wdata          = mem_rdata;
                copy_wr_valid_next = 1'b0;
                sweep_next         = '0;
                state_next         = ST_RUN;
            end
            default: begin
                state_next = ST_CLEAR;
                sweep_next = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        if (pend_adv) begin
            out_valid_next         = pend_valid_reg;
            out_next.cursor_row    = pend_reg.cursor_row;
            out_next.cursor_column = pend_reg.cursor_column;
            out_next.scrolled      = pend_reg.scrolled;
            out_next.read_data     = pend_reg.read_hit ? mem_rdata : '0;
            pend_valid_next        = 1'b0;
        end
        if (accept) begin
            pend_valid_next = 1'b1;
        end
    end

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the text console writer: a behavioral screen and
// cursor image predicts every result, which is compared field by field as it
// leaves the block. Directed reads and puts come first, then random text
// lines with reads and noise under three handshake pacing modes and several
// color settings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int CELLS      = TCW_ROWS * TCW_COLUMNS;
    localparam int CHUNK_SIZE = 322;

    typedef struct packed {
        logic                       opcode;
        logic [TCW_CHAR_WIDTH-1:0]  char_code;
        logic [TCW_INDEX_WIDTH-1:0] cell_index;
    } console_request_t;

    typedef struct packed {
        logic [TCW_CFG_IDX_WIDTH-1:0] index;
        logic [TCW_COLOR_WIDTH-1:0]   value;
    } color_write_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [TCW_S_TDATA_WIDTH-1:0]   s_axis_tdata  = '0;
    logic [0:0]                     s_axis_tuser  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [TCW_M_TDATA_WIDTH-1:0]   m_axis_tdata;
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [TCW_CFG_IDX_WIDTH-1:0]   cfg_index     = '0;
    logic [TCW_COLOR_WIDTH-1:0]     cfg_data      = '0;

    console_request_t pending_requests[$];
    color_write_t     pending_color_writes[$];
    tcw_result_t      expected_results[$];
    console_request_t active_request;
    color_write_t     active_color_write;

    int outstanding_requests = 0;
    int color_writes_waiting = 0;
    int send_idle_pct        = 0;
    int recv_stall_pct       = 0;
    int error_count          = 0;

    // screen and cursor image
    logic [TCW_CELL_WIDTH-1:0]  screen_image[CELLS];
    int                         console_row    = 0;
    int                         console_column = 0;
    logic [TCW_COLOR_WIDTH-1:0] fg_color       = '0;
    logic [TCW_COLOR_WIDTH-1:0] bg_color       = '0;

    int chars_seen    = 0;
    int newlines_seen = 0;
    int reads_seen    = 0;
    int scrolls_seen  = 0;
    int wraps_seen    = 0;
    int color_writes  = 0;

    text_console_writer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic tcw_result_t console_step(input console_request_t req);
        tcw_result_t res;
        int          i;
        res = '0;
        if (req.opcode == OP_READ) begin
            reads_seen++;
            if (req.cell_index < CELLS) begin
                res.read_data = screen_image[req.cell_index];
            end
        end else begin
            if (req.char_code == NEWLINE_CODE) begin
                newlines_seen++;
                console_column = 0;
                console_row++;
            end else begin
                chars_seen++;
                screen_image[console_row * TCW_COLUMNS + console_column] =
                    {bg_color, fg_color, req.char_code};
                console_column++;
            end
            if (console_column >= TCW_COLUMNS) begin
                wraps_seen++;
                console_column = 0;
                console_row++;
            end
            if (console_row >= TCW_ROWS - 1) begin
                // last row is copied up and also kept in place
                for (i = 0; i < (TCW_ROWS - 1) * TCW_COLUMNS; i++) begin
                    screen_image[i] = screen_image[i + TCW_COLUMNS];
                end
                console_row  = TCW_ROWS - 2;
                res.scrolled = 1'b1;
                scrolls_seen++;
            end
        end
        res.cursor_row    = console_row[TCW_ROW_WIDTH-1:0];
        res.cursor_column = console_column[TCW_COLUMN_WIDTH-1:0];
        return res;
    endfunction

    // request and color register driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            cfg_valid     <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(console_step(active_request));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    active_request = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b0, active_request.cell_index,
                                      active_request.char_code};
                    s_axis_tuser  <= active_request.opcode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end

            if (cfg_valid && cfg_ready) begin
                if (active_color_write.index == REG_TEXT_COLOR) begin
                    fg_color = active_color_write.value;
                end else if (active_color_write.index == REG_BACKGROUND_COLOR) begin
                    bg_color = active_color_write.value;
                end
                color_writes++;
                color_writes_waiting--;
            end
            if (!cfg_valid || cfg_ready) begin
                if (pending_color_writes.size() > 0) begin
                    active_color_write = pending_color_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= active_color_write.index;
                    cfg_data  <= active_color_write.value;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        tcw_result_t got;
        tcw_result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = tcw_result_t'(m_axis_tdata[$bits(tcw_result_t)-1:0]);
                if (expected_results.size() == 0) begin
                    $error("result with no request waiting: %h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    outstanding_requests--;
                    if (got.cursor_row !== want.cursor_row) begin
                        $error("cursor_row expected %0d actual %0d",
                               want.cursor_row, got.cursor_row);
                        error_count++;
                    end
                    if (got.cursor_column !== want.cursor_column) begin
                        $error("cursor_column expected %0d actual %0d",
                               want.cursor_column, got.cursor_column);
                        error_count++;
                    end
                    if (got.scrolled !== want.scrolled) begin
                        $error("scrolled expected %0d actual %0d",
                               want.scrolled, got.scrolled);
                        error_count++;
                    end
                    if (got.read_data !== want.read_data) begin
                        $error("read_data expected %h actual %h",
                               want.read_data, got.read_data);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_request(input logic op, input int code, input int index);
        console_request_t req;
        req.opcode     = op;
        req.char_code  = code[TCW_CHAR_WIDTH-1:0];
        req.cell_index = index[TCW_INDEX_WIDTH-1:0];
        pending_requests.push_back(req);
        outstanding_requests++;
    endtask

    task automatic set_colors(input int fg, input int bg);
        color_write_t wr;
        wr.index = REG_TEXT_COLOR;
        wr.value = fg[TCW_COLOR_WIDTH-1:0];
        pending_color_writes.push_back(wr);
        wr.index = REG_BACKGROUND_COLOR;
        wr.value = bg[TCW_COLOR_WIDTH-1:0];
        pending_color_writes.push_back(wr);
        color_writes_waiting += 2;
        do @(posedge aclk); while (color_writes_waiting != 0);
    endtask

    task automatic wait_for_drain();
        do @(posedge aclk); while (outstanding_requests != 0);
    endtask

    function automatic int text_char();
        int c;
        do c = $urandom_range(255); while (c == int'(NEWLINE_CODE));
        return c;
    endfunction

    function automatic int read_index();
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            return $urandom_range(1680, 1919);
        end else if (r < 85) begin
            return $urandom_range(0, CELLS - 1);
        end
        return $urandom_range(CELLS, 2047);
    endfunction

    task automatic add_random_chunk(input int count);
        int target;
        int kind;
        int len;
        int k;
        target = pending_requests.size() + count;
        while (pending_requests.size() < target) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                // a line of text, sometimes long enough to wrap
                len = ($urandom_range(9) == 0) ? $urandom_range(70, 100)
                                               : $urandom_range(0, 30);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(9) == 0) begin
                        add_request(OP_READ, $urandom_range(255), read_index());
                    end else begin
                        add_request(OP_PUT, text_char(), $urandom_range(2047));
                    end
                end
                if ($urandom_range(99) < 85) begin
                    add_request(OP_PUT, int'(NEWLINE_CODE), $urandom_range(2047));
                end
            end else if (kind < 90) begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++) begin
                    add_request(OP_READ, $urandom_range(255), read_index());
                end
            end else begin
                len = $urandom_range(1, 5);
                for (k = 0; k < len; k++) begin
                    add_request(1'($urandom_range(1)), $urandom_range(255),
                                $urandom_range(2047));
                end
            end
        end
    endtask

    initial begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        int phase;
        for (int i = 0; i < CELLS; i++) begin
            screen_image[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed requests
        send_idle_pct  = 20;
        recv_stall_pct = 58;
        set_colors(15, 0);
        add_request(OP_READ, 0, 0);
        add_request(OP_READ, 255, CELLS - 1);
        add_request(OP_READ, 0, CELLS);
        add_request(OP_READ, 0, 2047);
        add_request(OP_READ, 0, 1024);
        add_request(OP_PUT, 8'h00, 0);
        add_request(OP_PUT, 8'hFF, 2047);
        add_request(OP_PUT, 8'h41, 0);
        add_request(OP_PUT, int'(NEWLINE_CODE), 0);
        add_request(OP_READ, 0, 0);
        add_request(OP_READ, 0, 1);
        add_request(OP_READ, 0, 2);
        add_request(OP_READ, 0, 3);
        add_request(OP_PUT, 8'h7F, 0);
        add_request(OP_PUT, 8'h80, 0);
        add_request(OP_PUT, int'(NEWLINE_CODE), 0);
        add_request(OP_PUT, int'(NEWLINE_CODE), 0);
        add_request(OP_READ, 0, TCW_COLUMNS);
        add_request(OP_READ, 0, TCW_COLUMNS + 1);
        add_request(OP_READ, 0, TCW_COLUMNS + 2);
        wait_for_drain();

        for (phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                send_idle_pct  = 20;
                recv_stall_pct = 58;
            end else if (phase < 4) begin
                send_idle_pct  = 58;
                recv_stall_pct = 20;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (phase)
                0: set_colors(0, 15);
                1: set_colors(15, 15);
                3: set_colors(0, 0);
                default: set_colors($urandom_range(15), $urandom_range(15));
            endcase
            add_random_chunk(CHUNK_SIZE);
            wait_for_drain();
        end

        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end
        $display("testbench: %0d characters, %0d newlines, %0d reads", chars_seen,
                 newlines_seen, reads_seen);
        $display("testbench: %0d scrolls, %0d column wraps, %0d color register writes",
                 scrolls_seen, wraps_seen, color_writes);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
